// File: rtl/core/lmwc_pkg.sv
// Shared types and constants for the line midpoint window clipper.
// Used by lmwc_bisect_unit and line_midpoint_window_clipper_unit.
`timescale 1ns / 1ps

package lmwc_pkg;

  localparam int CoordW = 16;
  localparam int WinW   = 8;
  localparam int CodeW  = 4;
  localparam int StepW  = 5;

  // Outcode value that marks an endpoint behind the eye.
  localparam logic [CodeW-1:0] CODE_BEHIND = 4'hF;

  // Bisection step cap; a search ends well before it.
  localparam logic [StepW-1:0] STEP_LAST = 5'd31;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  localparam logic [WinW-1:0] LEFT_RESET   = 8'd0;
  localparam logic [WinW-1:0] RIGHT_RESET  = 8'd255;
  localparam logic [WinW-1:0] TOP_RESET    = 8'd0;
  localparam logic [WinW-1:0] BOTTOM_RESET = 8'd211;

  // Clip phases; bit 1 selects the axis, bit 0 set means the high edge.
  localparam logic [1:0] PH_LEFT   = 2'd0;
  localparam logic [1:0] PH_RIGHT  = 2'd1;
  localparam logic [1:0] PH_TOP    = 2'd2;
  localparam logic [1:0] PH_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic                     axis;   // 0 = x, 1 = y
    logic signed [CoordW-1:0] bound;
  } clip_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SETUP   = 5'b00010,
    ST_STEP    = 5'b00100,
    ST_ORDER_Y = 5'b01000,
    ST_EMIT    = 5'b10000
  } state_t;

endpackage

// File: rtl/core/lmwc_bisect_unit.sv
// One bisection step of the clipper: floor midpoint of both coordinates,
// compare against the clip edge and pick the half that keeps the edge.
// Depends on lmwc_pkg.
`timescale 1ns / 1ps

module lmwc_bisect_unit (
  input  lmwc_pkg::point_t    lo,
  input  lmwc_pkg::point_t    hi,
  input  lmwc_pkg::clip_ctl_t ctl,
  output lmwc_pkg::point_t    lo_next,
  output lmwc_pkg::point_t    hi_next,
  output logic                hit
);
  import lmwc_pkg::*;

  logic signed [CoordW:0]   sum_x;
  logic signed [CoordW:0]   sum_y;
  point_t                   mid;
  logic signed [CoordW-1:0] mid_ax;
  logic signed [CoordW-1:0] hi_ax;

  // The 17-bit sum shifted right by one is the floor of the mean.
  assign sum_x = {lo.x[CoordW-1], lo.x} + {hi.x[CoordW-1], hi.x};
  assign sum_y = {lo.y[CoordW-1], lo.y} + {hi.y[CoordW-1], hi.y};
  assign mid.x = sum_x[CoordW:1];
  assign mid.y = sum_y[CoordW:1];

  assign mid_ax = ctl.axis ? mid.y : mid.x;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (mid_ax < ctl.bound) begin
      lo_next = mid;
    end else begin
      hi_next = mid;
    end
  end

  assign hi_ax = ctl.axis ? hi_next.y : hi_next.x;
  assign hit   = (hi_ax == ctl.bound);

endmodule

// File: rtl/core/line_midpoint_window_clipper_unit.sv
// Line segment window clipper by midpoint bisection, one segment at a time.
// Endpoints are ordered by x, clipped at the left and right edges by bisection,
// reordered by y, clipped at the top and bottom edges and emitted as one beat.
// Each accepted segment keeps in_stall high until its beat is registered, which waits
// while a previous beat is stalled. A rejected segment produces no beat. Segments use
// the single shared bisection step unit one at a time. Synchronous active-high reset
// returns the sequencer to idle, drops the output beat and restores the window.
`timescale 1ns / 1ps

module line_midpoint_window_clipper_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [lmwc_pkg::WinW-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [lmwc_pkg::CoordW-1:0] start_x,
  input  logic signed [lmwc_pkg::CoordW-1:0] start_y,
  input  logic signed [lmwc_pkg::CoordW-1:0] end_x,
  input  logic signed [lmwc_pkg::CoordW-1:0] end_y,
  input  logic [lmwc_pkg::CodeW-1:0]      start_code,
  input  logic [lmwc_pkg::CodeW-1:0]      end_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lmwc_pkg::WinW-1:0]       draw_x0,
  output logic [lmwc_pkg::WinW-1:0]       draw_y0,
  output logic [lmwc_pkg::WinW-1:0]       draw_x1,
  output logic [lmwc_pkg::WinW-1:0]       draw_y1
);
  import lmwc_pkg::*;

  state_t            state;
  logic [1:0]        phase;
  logic [StepW-1:0]  cnt;
  logic [WinW-1:0]   window_left;
  logic [WinW-1:0]   window_right;
  logic [WinW-1:0]   window_top;
  logic [WinW-1:0]   window_bottom;
  point_t            s;
  point_t            e;
  point_t            lo;
  point_t            hi;

  point_t            lo_next;
  point_t            hi_next;
  logic              hit;
  clip_ctl_t         ctl;
  logic [WinW-1:0]   bound_raw;
  logic signed [CoordW-1:0] s_ax;
  logic signed [CoordW-1:0] e_ax;
  logic              clip_needed;
  logic              reject;
  point_t            in_s;
  point_t            in_e;
  state_t            after_phase;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    case (phase)
      PH_LEFT:   bound_raw = window_left;
      PH_RIGHT:  bound_raw = window_right;
      PH_TOP:    bound_raw = window_top;
      PH_BOTTOM: bound_raw = window_bottom;
      default:   bound_raw = window_left;
    endcase
  end

  assign ctl.axis  = phase[1];
  assign ctl.bound = signed'({{(CoordW-WinW){1'b0}}, bound_raw});

  assign s_ax        = ctl.axis ? s.y : s.x;
  assign e_ax        = ctl.axis ? e.y : e.x;
  assign clip_needed = (s_ax < ctl.bound) && (ctl.bound <= e_ax);

  // After the right edge the pair is reordered by y; after the bottom edge
  // the segment is done.
  always_comb begin
    case (phase)
      PH_RIGHT:  after_phase = ST_ORDER_Y;
      PH_BOTTOM: after_phase = ST_EMIT;
      default:   after_phase = ST_SETUP;
    endcase
  end

  assign reject = ((start_code & end_code) != '0) ||
                  (start_code == CODE_BEHIND) || (end_code == CODE_BEHIND);

  // Order the incoming endpoints by x; equal x keeps the given order.
  always_comb begin
    if (start_x > end_x) begin
      in_s = '{x: end_x, y: end_y};
      in_e = '{x: start_x, y: start_y};
    end else begin
      in_s = '{x: start_x, y: start_y};
      in_e = '{x: end_x, y: end_y};
    end
  end

  lmwc_bisect_unit u_bisect (
    .lo      (lo),
    .hi      (hi),
    .ctl     (ctl),
    .lo_next (lo_next),
    .hi_next (hi_next),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_LEFT;
      cnt           <= '0;
      out_valid     <= 1'b0;
      window_left   <= LEFT_RESET;
      window_right  <= RIGHT_RESET;
      window_top    <= TOP_RESET;
      window_bottom <= BOTTOM_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:   window_left   <= cfg_data;
          REG_RIGHT:  window_right  <= cfg_data;
          REG_TOP:    window_top    <= cfg_data;
          REG_BOTTOM: window_bottom <= cfg_data;
          default:    window_left   <= window_left;
        endcase
      end

      if ((state == ST_EMIT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid && !reject) begin
            s     <= in_s;
            e     <= in_e;
            phase <= PH_LEFT;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (clip_needed) begin
            lo    <= s;
            hi    <= e;
            cnt   <= '0;
            state <= ST_STEP;
          end else begin
            phase <= phase + 2'd1;
            state <= after_phase;
          end
        end
        ST_STEP: begin
          lo  <= lo_next;
          hi  <= hi_next;
          cnt <= cnt + 1'b1;
          if (hit || (cnt == STEP_LAST)) begin
            // A low-edge clip moves the first endpoint, a high-edge clip
            // moves the second one.
            if (!phase[0]) begin
              s <= hit ? hi_next : lo_next;
            end else begin
              e <= hi_next;
            end
            phase <= phase + 2'd1;
            state <= after_phase;
          end
        end
        ST_ORDER_Y: begin
          if (s.y > e.y) begin
            s <= e;
            e <= s;
          end
          state <= ST_SETUP;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            draw_x0   <= s.x[WinW-1:0];
            draw_y0   <= s.y[WinW-1:0];
            draw_x1   <= e.x[WinW-1:0];
            draw_y1   <= e.y[WinW-1:0];
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb_line_midpoint_window_clipper_unit.sv
// Self-checking bench for line_midpoint_window_clipper_unit: drives segments,
// predicts the clipped endpoints with a bisection model and compares each beat.
// Depends on lmwc_pkg and the clipper RTL only.
`timescale 1ns / 1ps

module tb_line_midpoint_window_clipper_unit;
  import lmwc_pkg::*;

  localparam int SegsPerPhase = 180;
  localparam int DrainWait    = 100;
  localparam int QuietLimit   = 2000;
  localparam int MaxBisect    = 32;

  // Outcode bits.
  localparam logic [CodeW-1:0] OC_RIGHT  = 4'b0001;
  localparam logic [CodeW-1:0] OC_LEFT   = 4'b0010;
  localparam logic [CodeW-1:0] OC_BOTTOM = 4'b0100;
  localparam logic [CodeW-1:0] OC_TOP    = 4'b1000;

  typedef struct packed {
    logic signed [CoordW-1:0] sx, sy, ex, ey;
    logic [CodeW-1:0]         sc, ec;
  } segment_t;

  typedef struct packed {
    logic [WinW-1:0] x0, y0, x1, y1;
  } draw_t;

  typedef enum int {IDLE_BOTH, IDLE_NONE, IDLE_SEND, IDLE_RECV} idle_mode_t;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            cfg_we    = 1'b0;
  logic [1:0]      cfg_index = REG_LEFT;
  logic [WinW-1:0] cfg_data  = '0;
  logic            in_valid  = 1'b0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic [WinW-1:0] draw_x0, draw_y0, draw_x1, draw_y1;
  segment_t        seg_on_bus = '0;

  segment_t        seg_backlog[$];
  draw_t           clip_expect[$];
  logic [WinW-1:0] win_cfg [4];
  idle_mode_t      idle_mode = IDLE_BOTH;

  int segs_taken    = 0;
  int segs_shown    = 0;
  int send_gap      = -1;
  int recv_wait     = 0;
  int beats_seen    = 0;
  int beats_handled = 0;
  int quiet_cycles  = 0;
  int fails         = 0;

  always #2 clk = ~clk;

  line_midpoint_window_clipper_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_x   (seg_on_bus.sx),
    .start_y   (seg_on_bus.sy),
    .end_x     (seg_on_bus.ex),
    .end_y     (seg_on_bus.ey),
    .start_code(seg_on_bus.sc),
    .end_code  (seg_on_bus.ec),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .draw_x0   (draw_x0),
    .draw_y0   (draw_y0),
    .draw_x1   (draw_x1),
    .draw_y1   (draw_y1)
  );

  task automatic report_mismatch(input string msg);
    fails++;
    $display("mismatch at beat %0d: %s", beats_seen, msg);
  endtask

  function automatic bit culled(input segment_t seg);
    return ((seg.sc & seg.ec) != '0) || seg.sc == CODE_BEHIND || seg.ec == CODE_BEHIND;
  endfunction

  // Floor-midpoint search from lo toward hi; hi ends on the edge.
  function automatic void bisect_to_edge(input bit on_y, input int edge_at,
                                         input int lo_x, input int lo_y,
                                         inout int hi_x, inout int hi_y);
    int mid_x, mid_y;
    for (int i = 0; i < MaxBisect; i++) begin
      mid_x = (lo_x + hi_x) >>> 1;
      mid_y = (lo_y + hi_y) >>> 1;
      if ((on_y ? mid_y : mid_x) < edge_at) begin
        lo_x = mid_x;
        lo_y = mid_y;
      end else begin
        hi_x = mid_x;
        hi_y = mid_y;
      end
      if ((on_y ? hi_y : hi_x) == edge_at) break;
    end
  endfunction

  function automatic bit clip_segment(input segment_t seg, output draw_t d);
    int sx, sy, ex, ey, tx, ty;
    int edge_l, edge_r, edge_t, edge_b;
    d = '0;
    if (culled(seg)) return 1'b0;
    sx = $signed(seg.sx);
    sy = $signed(seg.sy);
    ex = $signed(seg.ex);
    ey = $signed(seg.ey);
    edge_l = win_cfg[REG_LEFT];
    edge_r = win_cfg[REG_RIGHT];
    edge_t = win_cfg[REG_TOP];
    edge_b = win_cfg[REG_BOTTOM];
    if (sx > ex) begin
      tx = sx; ty = sy; sx = ex; sy = ey; ex = tx; ey = ty;
    end
    if (sx < edge_l && edge_l <= ex) begin
      tx = ex; ty = ey;
      bisect_to_edge(1'b0, edge_l, sx, sy, tx, ty);
      sx = tx; sy = ty;
    end
    if (sx < edge_r && edge_r <= ex) bisect_to_edge(1'b0, edge_r, sx, sy, ex, ey);
    if (sy > ey) begin
      tx = sx; ty = sy; sx = ex; sy = ey; ex = tx; ey = ty;
    end
    if (sy < edge_t && edge_t <= ey) begin
      tx = ex; ty = ey;
      bisect_to_edge(1'b1, edge_t, sx, sy, tx, ty);
      sx = tx; sy = ty;
    end
    if (sy < edge_b && edge_b <= ey) bisect_to_edge(1'b1, edge_b, sx, sy, ex, ey);
    d.x0 = 8'(sx);
    d.y0 = 8'(sy);
    d.x1 = 8'(ex);
    d.y1 = 8'(ey);
    return 1'b1;
  endfunction

  function automatic logic [CodeW-1:0] true_code(input int x, input int y);
    logic [CodeW-1:0] code;
    int edge_l, edge_r, edge_t, edge_b;
    edge_l = win_cfg[REG_LEFT];
    edge_r = win_cfg[REG_RIGHT];
    edge_t = win_cfg[REG_TOP];
    edge_b = win_cfg[REG_BOTTOM];
    code = '0;
    if (x > edge_r) code |= OC_RIGHT;
    if (x < edge_l) code |= OC_LEFT;
    if (y > edge_b) code |= OC_BOTTOM;
    if (y < edge_t) code |= OC_TOP;
    return code;
  endfunction

  function automatic int rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 860)) - 300;
      6, 7:             v = $signed(16'($urandom));
      8: begin
        case ($urandom_range(0, 5))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          3:       v = 0;
          4:       v = 255;
          default: v = 256;
        endcase
      end
      default: v = int'(win_cfg[$urandom_range(0, 3)]) + int'($urandom_range(0, 4)) - 2;
    endcase
    return v;
  endfunction

  // Mostly honest outcodes; the rest are random, behind-the-eye or blank.
  function automatic segment_t rand_segment();
    segment_t seg;
    seg.sx = 16'(rand_coord());
    seg.sy = 16'(rand_coord());
    seg.ex = 16'(rand_coord());
    seg.ey = 16'(rand_coord());
    case ($urandom_range(0, 9))
      7: begin
        seg.sc = 4'($urandom_range(0, 15));
        seg.ec = 4'($urandom_range(0, 15));
      end
      8: begin
        seg.sc = CODE_BEHIND;
        seg.ec = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) begin
          seg.ec = seg.sc;
          seg.sc = 4'($urandom_range(0, 15));
        end
      end
      9: begin
        seg.sc = '0;
        seg.ec = '0;
      end
      default: begin
        seg.sc = true_code($signed(seg.sx), $signed(seg.sy));
        seg.ec = true_code($signed(seg.ex), $signed(seg.ey));
      end
    endcase
    return seg;
  endfunction

  function automatic void queue_seg(input int sx, input int sy, input int ex, input int ey,
                                    input logic [CodeW-1:0] sc, input logic [CodeW-1:0] ec);
    segment_t seg;
    seg.sx = 16'(sx);
    seg.sy = 16'(sy);
    seg.ex = 16'(ex);
    seg.ey = 16'(ey);
    seg.sc = sc;
    seg.ec = ec;
    seg_backlog.push_back(seg);
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [WinW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    win_cfg[idx] = val;
  endtask

  task automatic set_window(input logic [WinW-1:0] l, input logic [WinW-1:0] r,
                            input logic [WinW-1:0] t, input logic [WinW-1:0] b);
    write_reg(REG_LEFT, l);
    write_reg(REG_RIGHT, r);
    write_reg(REG_TOP, t);
    write_reg(REG_BOTTOM, b);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender until every expected beat is back, then lets the block settle.
  task automatic wait_drained();
    while (seg_backlog.size() != 0 || in_valid || clip_expect.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  always @(negedge clk) begin : seg_driver
    logic next_valid;
    if (segs_taken == segs_shown) begin
      next_valid = 1'b0;
      if (seg_backlog.size() != 0) begin
        if (send_gap < 0)
          send_gap = (idle_mode == IDLE_NONE || idle_mode == IDLE_RECV) ? 0
                                                                        : $urandom_range(0, 12);
        if (send_gap == 0) begin
          seg_on_bus <= seg_backlog.pop_front();
          segs_shown++;
          next_valid = 1'b1;
          send_gap = -1;
        end else begin
          send_gap--;
        end
      end
      in_valid <= next_valid;
    end
  end

  // The stall count is drawn per beat and only runs down while a beat is offered.
  always @(negedge clk) begin : beat_stall
    if (beats_seen != beats_handled) begin
      beats_handled = beats_seen;
      recv_wait = (idle_mode == IDLE_NONE || idle_mode == IDLE_SEND) ? 0
                                                                     : $urandom_range(0, 12);
    end
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid) recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : beat_monitor
    draw_t fresh, got, want;
    if (!rst) begin
      quiet_cycles++;
      if (cfg_we) quiet_cycles = 0;
      if (in_valid && !in_stall) begin
        if (clip_segment(seg_on_bus, fresh)) clip_expect.push_back(fresh);
        segs_taken++;
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        got = {draw_x0, draw_y0, draw_x1, draw_y1};
        beats_seen++;
        quiet_cycles = 0;
        if (clip_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %0d,%0d -> %0d,%0d",
                                    got.x0, got.y0, got.x1, got.y1));
        end else begin
          want = clip_expect.pop_front();
          if (got.x0 !== want.x0)
            report_mismatch($sformatf("draw_x0 got %0d want %0d", got.x0, want.x0));
          if (got.y0 !== want.y0)
            report_mismatch($sformatf("draw_y0 got %0d want %0d", got.y0, want.y0));
          if (got.x1 !== want.x1)
            report_mismatch($sformatf("draw_x1 got %0d want %0d", got.x1, want.x1));
          if (got.y1 !== want.y1)
            report_mismatch($sformatf("draw_y1 got %0d want %0d", got.y1, want.y1));
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no beat for %0d cycles, %0d expected", QuietLimit,
                 clip_expect.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int kept;
    segment_t seg;
    logic [WinW-1:0] wl, wr;
    win_cfg[REG_LEFT]   = LEFT_RESET;
    win_cfg[REG_RIGHT]  = RIGHT_RESET;
    win_cfg[REG_TOP]    = TOP_RESET;
    win_cfg[REG_BOTTOM] = BOTTOM_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed segments under the reset window.
    queue_seg(10, 10, 200, 100, '0, '0);
    queue_seg(-32768, -32768, 32767, 32767, OC_LEFT | OC_TOP, OC_RIGHT | OC_BOTTOM);
    queue_seg(32767, -32768, -32768, 32767, OC_RIGHT | OC_TOP, OC_LEFT | OC_BOTTOM);
    queue_seg(32767, 0, -32768, 0, OC_RIGHT, OC_LEFT);
    queue_seg(-50, 10, -10, 20, OC_LEFT, OC_LEFT);
    queue_seg(10, 10, 20, 20, CODE_BEHIND, '0);
    queue_seg(10, 10, 20, 20, '0, CODE_BEHIND);
    queue_seg(10, 10, 20, 20, CODE_BEHIND, CODE_BEHIND);
    queue_seg(10, 10, 20, 20, OC_RIGHT, OC_RIGHT | OC_LEFT);
    queue_seg(100, -500, 100, 500, OC_TOP, OC_BOTTOM);
    queue_seg(-1000, 50, 1000, 50, OC_LEFT, OC_RIGHT);
    queue_seg(100, 100, 100, 100, '0, '0);
    queue_seg(50, 300, 50, -20, OC_BOTTOM, OC_TOP);
    queue_seg(0, 20, -40, 60, '0, OC_LEFT);
    queue_seg(255, 10, 300, 40, '0, OC_RIGHT);
    queue_seg(10, 211, 20, 400, '0, OC_BOTTOM);
    // Edge cases, some with outcodes that lie about the coordinates: clipping follows the coordinates.
    queue_seg(-100, -100, -50, -60, '0, '0);
    queue_seg(-1, -1, 256, 212, OC_LEFT | OC_TOP, OC_RIGHT | OC_BOTTOM);
    queue_seg(400, 100, -200, 150, OC_RIGHT, OC_LEFT);
    queue_seg(120, -32768, 130, 32767, OC_TOP, OC_BOTTOM);
    queue_seg(-1, -1, -1, -1, '0, '0);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1: set_window(8'd0, 8'd255, 8'd0, 8'd255);
          2: set_window(8'd255, 8'd0, 8'd255, 8'd0);     // misordered on both axes
          3: set_window(8'd100, 8'd100, 8'd60, 8'd60);
          4: set_window(8'd16, 8'd240, 8'd32, 8'd200);
          default: begin
            wl = 8'($urandom_range(0, 255));
            wr = 8'($urandom_range(0, 255));
            if (wl > wr) set_window(wr, wl, 8'($urandom_range(0, 120)),
                                    8'($urandom_range(121, 255)));
            else set_window(wl, wr, 8'($urandom_range(0, 120)), 8'($urandom_range(121, 255)));
          end
        endcase
      end
      idle_mode = idle_mode_t'(phase % 4);
      kept = 0;
      while (kept < SegsPerPhase) begin
        seg = rand_segment();
        seg_backlog.push_back(seg);
        kept++;
      end
    end

    wait_drained();
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
